// File: rtl/bbw_pkg.sv
// Shared constants, codes and control types for the box blur block.
package bbw_pkg;

  localparam int PIX_W = 8;
  localparam int POS_W = 8;
  localparam int K_W = 6;
  localparam int CFG_W = 9;
  localparam int IDX_W = 2;
  localparam int KK_W = 2 * K_W;
  // Largest window sum: 63 * 63 * 255 fits in 20 bits.
  localparam int SUM_W = 20;
  localparam int DCNT_W = $clog2(SUM_W);

  localparam int DEF_MAX_ROWS = 256;
  localparam int DEF_MAX_COLS = 256;

  localparam logic [IDX_W-1:0] REG_KERNEL = 2'd0;
  localparam logic [IDX_W-1:0] REG_ROWS = 2'd1;
  localparam logic [IDX_W-1:0] REG_COLS = 2'd2;

  localparam logic [K_W-1:0] KERNEL_RST = 6'd3;

  typedef struct packed {
    logic wr;
    logic load;
    logic mod_step;
    logic base;
    logic scan;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic mod_done;
    logic scan_last;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/box_blur_wrap_border.sv
// Top level of the wrap-border box blur block.
// A write item (mode 0) stores one pixel and gives no result. A query
// (mode 1) returns floor(window sum / k^2) over the k-by-k window centred on row/col with
// periodic wrap at the frame edges. The window is read one pixel a cycle through the single
// frame-store read port, after a subtract loop of at most 255 steps reduces the centre and
// half-width modulo the frame size; a bit-serial divider then forms the quotient. One query
// runs at a time; a finished result waits in the output register while the next item is taken.
module box_blur_wrap_border #(
  parameter int MAX_ROWS = bbw_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = bbw_pkg::DEF_MAX_COLS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  logic                      mode,
  input  logic [bbw_pkg::POS_W-1:0] row,
  input  logic [bbw_pkg::POS_W-1:0] col,
  input  logic [bbw_pkg::PIX_W-1:0] pixel,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic [bbw_pkg::POS_W-1:0] out_row,
  output logic [bbw_pkg::POS_W-1:0] out_col,
  output logic [bbw_pkg::PIX_W-1:0] mean_value,
  input  logic                      cfg_we,
  input  logic [bbw_pkg::IDX_W-1:0] cfg_addr,
  input  logic [bbw_pkg::CFG_W-1:0] cfg_data
);
  import bbw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bbw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .mode     (mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  bbw_dp #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .row       (row),
    .col       (col),
    .pixel     (pixel),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .out_row   (out_row),
    .out_col   (out_col),
    .mean_value(mean_value)
  );
endmodule

// File: rtl/bbw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bbw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/bbw_ctrl.sv
// Sequencer for writes and window queries of the box blur block.
module bbw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  logic          mode,
  input  bbw_pkg::sts_t sts,
  output bbw_pkg::cmd_t cmd
);
  import bbw_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MOD   = 3'd1;
  localparam logic [2:0] ST_BASE  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_DINIT = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    req_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (mode) begin
            cmd.load = 1'b1;
            state_next = ST_MOD;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_done) begin
          state_next = ST_BASE;
        end
      end
      ST_BASE: begin
        cmd.base = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_DINIT;
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// File: rtl/bbw_dp.sv
// Datapath: configuration, frame store, window walk, accumulator, divider, output.
module bbw_dp #(
  parameter int MAX_ROWS = bbw_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = bbw_pkg::DEF_MAX_COLS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bbw_pkg::cmd_t               cmd,
  output bbw_pkg::sts_t               sts,
  input  logic                        cfg_we,
  input  logic [bbw_pkg::IDX_W-1:0]   cfg_addr,
  input  logic [bbw_pkg::CFG_W-1:0]   cfg_data,
  input  logic [bbw_pkg::POS_W-1:0]   row,
  input  logic [bbw_pkg::POS_W-1:0]   col,
  input  logic [bbw_pkg::PIX_W-1:0]   pixel,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [bbw_pkg::POS_W-1:0]   out_row,
  output logic [bbw_pkg::POS_W-1:0]   out_col,
  output logic [bbw_pkg::PIX_W-1:0]   mean_value
);
  import bbw_pkg::*;

  localparam int RSW = $clog2(MAX_ROWS + 1);
  localparam int CSW = $clog2(MAX_COLS + 1);
  localparam int VW0 = (RSW > CSW) ? RSW : CSW;
  localparam int VW = (VW0 > POS_W) ? VW0 : POS_W;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW = RW + CW;

  logic [K_W-1:0]   kernel_size;
  logic [CFG_W-1:0] image_rows, image_cols;
  logic [VW-1:0]    rows, cols;
  logic [K_W-1:0]   k;
  logic [K_W-1:0]   half;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_size <= KERNEL_RST;
      image_rows <= CFG_W'(256);
      image_cols <= CFG_W'(256);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_KERNEL: kernel_size <= cfg_data[K_W-1:0];
        REG_ROWS:   image_rows <= cfg_data;
        REG_COLS:   image_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate the frame size into 1..MAX.
  always_comb begin
    if (image_rows == '0) rows = VW'(1);
    else if (int'(image_rows) > MAX_ROWS) rows = VW'(MAX_ROWS);
    else rows = VW'(image_rows);
    if (image_cols == '0) cols = VW'(1);
    else if (int'(image_cols) > MAX_COLS) cols = VW'(MAX_COLS);
    else cols = VW'(image_cols);
  end

  assign k = kernel_size | K_W'(1);
  assign half = k >> 1;

  // Query registers and reduction by repeated subtraction.
  logic [POS_W-1:0] q_row, q_col;
  logic [VW-1:0]    cr, cc, pr, pc;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_row <= row;
      q_col <= col;
      cr <= VW'(row);
      cc <= VW'(col);
      pr <= VW'(half);
      pc <= VW'(half);
    end else if (cmd.mod_step) begin
      if (cr >= rows) cr <= cr - rows;
      if (cc >= cols) cc <= cc - cols;
      if (pr >= rows) pr <= pr - rows;
      if (pc >= cols) pc <= pc - cols;
    end
  end

  assign sts.mod_done = (cr < rows) && (cc < cols) && (pr < rows) && (pc < cols);

  // Window origin: one compare and subtract, the sum stays below twice the size.
  logic [VW:0]   rsum, csum;
  logic [VW-1:0] r0, c0;

  always_comb begin
    rsum = {1'b0, cr} + {1'b0, rows} - {1'b0, pr};
    csum = {1'b0, cc} + {1'b0, cols} - {1'b0, pc};
    r0 = (rsum >= {1'b0, rows}) ? VW'(rsum - {1'b0, rows}) : VW'(rsum);
    c0 = (csum >= {1'b0, cols}) ? VW'(csum - {1'b0, cols}) : VW'(csum);
  end

  // Window walk.
  logic [VW-1:0]  rr, cw, c_start;
  logic [K_W-1:0] ri, ci;
  logic [KK_W-1:0] kk;
  logic [VW:0]    rr_inc, cw_inc;
  logic           rd_pend;
  logic [SUM_W-1:0] acc;
  logic [PIX_W-1:0] rdata;

  assign rr_inc = {1'b0, rr} + (VW + 1)'(1);
  assign cw_inc = {1'b0, cw} + (VW + 1)'(1);
  assign sts.scan_last = (ri == k - K_W'(1)) && (ci == k - K_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.base) begin
      rr <= r0;
      cw <= c0;
      c_start <= c0;
      ri <= '0;
      ci <= '0;
      kk <= KK_W'(k) * KK_W'(k);
    end else if (cmd.scan) begin
      if (ci == k - K_W'(1)) begin
        ci <= '0;
        cw <= c_start;
        ri <= ri + K_W'(1);
        rr <= (rr_inc >= {1'b0, rows}) ? '0 : VW'(rr_inc);
      end else begin
        ci <= ci + K_W'(1);
        cw <= (cw_inc >= {1'b0, cols}) ? '0 : VW'(cw_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.base) begin
      acc <= '0;
    end else if (rd_pend) begin
      acc <= acc + SUM_W'(rdata);
    end
  end

  logic wr_en;
  assign wr_en = cmd.wr && (int'(row) < MAX_ROWS) && (int'(col) < MAX_COLS);

  bbw_ram #(
    .WIDTH(PIX_W),
    .DEPTH(1 << AW)
  ) u_frame (
    .clk  (clk),
    .we   (wr_en),
    .waddr({RW'(row), CW'(col)}),
    .wdata(pixel),
    .raddr({RW'(rr), CW'(cw)}),
    .rdata(rdata)
  );

  // Restoring divider, one quotient bit a cycle.
  logic [SUM_W-1:0]  dq;
  logic [KK_W-1:0]   rem;
  logic [KK_W:0]     trial;
  logic [DCNT_W-1:0] dcnt;

  assign trial = {rem, dq[SUM_W-1]};
  assign sts.div_last = (dcnt == DCNT_W'(SUM_W - 1));

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dq <= acc;
      rem <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      dcnt <= dcnt + DCNT_W'(1);
      if (trial >= {1'b0, kk}) begin
        rem <= KK_W'(trial - {1'b0, kk});
        dq <= {dq[SUM_W-2:0], 1'b1};
      end else begin
        rem <= KK_W'(trial);
        dq <= {dq[SUM_W-2:0], 1'b0};
      end
    end
  end

  // Output register.
  assign sts.out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row <= q_row;
      out_col <= q_col;
      mean_value <= dq[PIX_W-1:0];
    end
  end
endmodule

// File: rtl/bbw_checker.sv
// Port-level checks for the box blur block, bound to the top level.
module bbw_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      mode,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic [bbw_pkg::POS_W-1:0] out_row,
  input logic [bbw_pkg::POS_W-1:0] out_col,
  input logic [bbw_pkg::PIX_W-1:0] mean_value
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(out_row) && $stable(out_col)
      && $stable(mean_value))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !mode && !res_valid |=> !res_valid)
    else $error("pixel write produced a result");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && mode |=> !req_ready)
    else $error("query transfer did not start a busy period");
endmodule

bind box_blur_wrap_border bbw_checker u_bbw_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .mode      (mode),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .out_row   (out_row),
  .out_col   (out_col),
  .mean_value(mean_value)
);
